// ===== src/stereo_block_peak_rms_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stereo block meter
// Shared helpers for concurrent checks on clock and async low reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_BLOCK_PEAK_RMS_METER_MACROS_SVH
`define STEREO_BLOCK_PEAK_RMS_METER_MACROS_SVH

// same-cycle implication
`define SBM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sbm check failed");

// next-cycle implication
`define SBM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sbm check failed");

`endif

// ===== src/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants of the stereo block peak/RMS meter.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int unsigned FIELD_W = 24;
  localparam int unsigned LEVEL_W = 16;

  // 20*log10(2)*256 in Q16
  localparam logic [26:0] DB_SCALE_Q16 = 27'd101008905;
  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -16'sd25600;
  localparam logic [16:0] LEVEL_FLOOR_MAG = 17'd25600;
  localparam logic [FIELD_W-1:0] CLIP_THR_RST = 24'd8380219;

  // register indexes
  localparam logic REG_MONO = 1'b0;
  localparam logic REG_THR  = 1'b1;

  // per-lane control from the sequencer
  typedef struct packed {
    logic smp_en;
    logic clr;
    logic div_ld;
    logic div_step;
    logic sqrt_ld;
    logic sqrt_step;
  } lane_ctrl_t;

  // control of the merge stage
  typedef struct packed {
    logic start;
    logic step;
    logic mul;
  } merge_ctrl_t;

endpackage

// ===== src/sbm_if.sv =====
// ----------------------------------------------------------------------------
// sbm stream interfaces
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface sbm_in_if import sbm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] left_sample;
  logic signed [FIELD_W-1:0] right_sample;
  logic                      last_in_block;

  modport source (output valid, left_sample, right_sample, last_in_block, input ready);
  modport sink   (input valid, left_sample, right_sample, last_in_block, output ready);
endinterface

interface sbm_out_if import sbm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [FIELD_W-1:0] peak_left;
  logic        [FIELD_W-1:0] peak_right;
  logic        [FIELD_W-1:0] rms_left;
  logic        [FIELD_W-1:0] rms_right;
  logic        [FIELD_W-1:0] max_peak;
  logic                      clip_seen;
  logic signed [LEVEL_W-1:0] level_db;

  modport source (output valid, peak_left, peak_right, rms_left, rms_right, max_peak,
                  clip_seen, level_db, input ready);
  modport sink   (input valid, peak_left, peak_right, rms_left, rms_right, max_peak,
                  clip_seen, level_db, output ready);
endinterface

// ===== src/sbm_lane.sv =====
// ----------------------------------------------------------------------------
// sbm_lane
// One channel: peak and energy accumulation, block divide and square root.
// ----------------------------------------------------------------------------
module sbm_lane import sbm_pkg::*; #(
  parameter int unsigned SB = 24,
  parameter int unsigned EW = 63,
  parameter int unsigned CW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lane_ctrl_t    ctrl_i,
  input  logic [SB-1:0] sample_i,
  input  logic [CW-1:0] count_i,
  output logic [SB-1:0] peak_o,
  output logic [SB-1:0] rms_o
);

  logic [SB-1:0]   mag;
  logic [2*SB-1:0] sq_q;
  logic            sq_v_q;
  logic [EW-1:0]   energy_q;
  logic [SB-1:0]   peak_q;
  logic [CW:0]     rem_q, rem_sh, divisor;
  logic [EW-1:0]   dv_q;
  logic            div_ge;
  logic [2*SB-1:0] rad_q;
  logic [SB+1:0]   srem_q;
  logic [SB-1:0]   root_q;
  logic [SB+3:0]   r4, trial;
  logic            sq_ge;

  // two's complement magnitude, most negative code maps to full scale
  assign mag = sample_i[SB-1] ? (~sample_i + 1'b1) : sample_i;

  // square is registered before the accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else begin
      sq_v_q <= ctrl_i.smp_en;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= mag * mag;
  end

  // block accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
      peak_q   <= '0;
    end else begin
      if (ctrl_i.clr) begin
        energy_q <= '0;
      end else if (sq_v_q) begin
        energy_q <= energy_q + EW'(sq_q);
      end
      if (ctrl_i.clr) begin
        peak_q <= '0;
      end else if (ctrl_i.smp_en && (mag > peak_q)) begin
        peak_q <= mag;
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  assign divisor = (count_i == '0) ? (CW+1)'(1) : {1'b0, count_i};
  assign rem_sh  = {rem_q[CW-1:0], dv_q[EW-1]};
  assign div_ge  = (rem_sh >= divisor);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_ld) begin
      rem_q <= '0;
      dv_q  <= energy_q;
    end else if (ctrl_i.div_step) begin
      rem_q <= div_ge ? (rem_sh - divisor) : rem_sh;
      dv_q  <= {dv_q[EW-2:0], div_ge};
    end
  end

  // digit-by-digit square root, one root bit per cycle
  assign r4    = {srem_q, rad_q[2*SB-1 -: 2]};
  assign trial = (SB+4)'({root_q, 2'b01});
  assign sq_ge = (r4 >= trial);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqrt_ld) begin
      rad_q  <= dv_q[2*SB-1:0];
      srem_q <= '0;
      root_q <= '0;
    end else if (ctrl_i.sqrt_step) begin
      rad_q  <= {rad_q[2*SB-3:0], 2'b00};
      srem_q <= sq_ge ? (SB+2)'(r4 - trial) : (SB+2)'(r4);
      root_q <= {root_q[SB-2:0], sq_ge};
    end
  end

  assign peak_o = peak_q;
  assign rms_o  = root_q;

endmodule

// ===== src/sbm_merge.sv =====
// ----------------------------------------------------------------------------
// sbm_merge
// Combines both RMS values into a level in 1/256 dB via a log2 unit.
// ----------------------------------------------------------------------------
module sbm_merge import sbm_pkg::*; #(
  parameter int unsigned SB = 24
) (
  input  logic                      clk_i,
  input  merge_ctrl_t               ctrl_i,
  input  logic [SB-1:0]             rms_l_i,
  input  logic [SB-1:0]             rms_r_i,
  output logic signed [LEVEL_W-1:0] level_o
);

  localparam int unsigned EXP_W = $clog2(SB + 1);
  localparam int unsigned LG_W  = EXP_W + 16;
  localparam int unsigned PW    = LG_W + 27;
  localparam logic [LG_W-1:0] REF_LG = LG_W'(SB) << 16;

  logic [SB:0]       s;
  logic [EXP_W-1:0]  e;
  logic [30:0]       x_q;
  logic [61:0]       sqr;
  logic [31:0]       t;
  logic [EXP_W-1:0]  e_q;
  logic [15:0]       frac_q;
  logic              zero_q, over_q;
  logic [LG_W-1:0]   lg;
  logic [PW-1:0]     prod_q;
  logic [PW:0]       rnd;
  logic [16:0]       q;

  assign s = {1'b0, rms_l_i} + {1'b0, rms_r_i};

  // top set bit of the RMS sum
  always_comb begin
    e = '0;
    for (int i = 0; i <= SB; i++) begin
      if (s[i]) e = EXP_W'(i);
    end
  end

  // log2 by repeated squaring of the Q30 mantissa
  assign sqr = x_q * x_q;
  assign t   = sqr[61:30];
  assign lg  = {e_q, frac_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q    <= 31'(s) << (5'd30 - 5'(e));
      e_q    <= e;
      frac_q <= '0;
      zero_q <= (s == '0);
    end else if (ctrl_i.step) begin
      x_q    <= t[31] ? t[31:1] : t[30:0];
      frac_q <= {frac_q[14:0], t[31]};
    end
    if (ctrl_i.mul) begin
      prod_q <= PW'(REF_LG - lg) * PW'(DB_SCALE_Q16);
      over_q <= (lg >= REF_LG);
    end
  end

  // round half up, then clamp to the floor
  assign rnd = {1'b0, prod_q} + (PW+1)'(64'h8000_0000);
  assign q   = 17'(rnd >> 32);

  always_comb begin
    priority if (zero_q) begin
      level_o = LEVEL_FLOOR;
    end else if (over_q) begin
      level_o = '0;
    end else if (q >= LEVEL_FLOOR_MAG) begin
      level_o = LEVEL_FLOOR;
    end else begin
      level_o = -$signed(LEVEL_W'(q));
    end
  end

endmodule

// ===== src/stereo_block_peak_rms_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_block_peak_rms_meter
// Stereo block peak/RMS meter with sticky clip flag and dB level output.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one stereo sample pair per item; last_in_block closes a
//   block. out_if carries one result item per closed block.
//   Samples are taken one per cycle while a block accumulates.
//   After the last sample the meter is busy while the bit-serial divider
//   and root unit in each lane, the 16-step log2 unit in the merge stage
//   and the dB scaling run, and until the result is loaded into the output
//   register. in_if.ready is low during that time.
//   The result sits in an output register: a new block can start while the
//   receiver stalls; a second result then waits until the first is taken.
//   Reset clears accumulators, sample count, clip flag and registers
//   (mono off, clip threshold 0.999 full scale).
//   The user is to write configuration through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while the meter is idle; the meter itself does not enforce this.
// ----------------------------------------------------------------------------
module stereo_block_peak_rms_meter import sbm_pkg::*; #(
  parameter int unsigned MAX_BLOCK   = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  sbm_in_if.sink             in_if,
  sbm_out_if.source          out_if
);

  `include "stereo_block_peak_rms_meter_macros.svh"

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned EW    = 2 * SB + 15;
  localparam int unsigned CW    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned CNT_W = $clog2(EW + 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(EW);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SB);
  localparam logic [CNT_W-1:0] LOG_LAST  = CNT_W'(16);

  typedef enum logic [6:0] {
    ST_ACC   = 7'b0000001,
    ST_FLUSH = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SQRT  = 7'b0001000,
    ST_LOG   = 7'b0010000,
    ST_DB    = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      mono_q;
  logic [FIELD_W-1:0]        thr_q;
  logic [CW-1:0]             count_q;
  logic                      clip_q;
  logic                      in_acc, smp_en, out_free, out_load, clip_now;
  lane_ctrl_t                lctrl;
  merge_ctrl_t               mctrl;
  logic [SB-1:0]             right_smp;
  logic [SB-1:0]             pk_l, pk_r, rms_l, rms_r;
  logic signed [LEVEL_W-1:0] level;
  logic                      out_v_q;
  logic [FIELD_W-1:0]        pk_l_q, pk_r_q, rms_l_q, rms_r_q, max_q;
  logic                      clip_out_q;
  logic signed [LEVEL_W-1:0] level_q;

  // handshakes
  assign in_if.ready = (state_q == ST_ACC);
  assign in_acc      = in_if.valid && in_if.ready;
  assign smp_en      = in_acc && (count_q < CW'(MAX_BLOCK));
  assign out_free    = !out_v_q || out_if.ready;
  assign out_load    = (state_q == ST_OUT) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q <= 1'b0;
      thr_q  <= CLIP_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MONO: mono_q <= cfg_wdata_i[0];
        REG_THR:  thr_q  <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_ACC: begin
        if (in_acc && in_if.last_in_block) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_q == SQRT_LAST) begin
          state_d = ST_LOG;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LOG: begin
        if (cnt_q == LOG_LAST) begin
          state_d = ST_DB;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DB: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_ACC;
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // lane and merge control
  always_comb begin
    lctrl.smp_en    = smp_en;
    lctrl.clr       = out_load;
    lctrl.div_ld    = (state_q == ST_DIV) && (cnt_q == '0);
    lctrl.div_step  = (state_q == ST_DIV) && (cnt_q != '0);
    lctrl.sqrt_ld   = (state_q == ST_SQRT) && (cnt_q == '0);
    lctrl.sqrt_step = (state_q == ST_SQRT) && (cnt_q != '0);
    mctrl.start     = (state_q == ST_LOG) && (cnt_q == '0);
    mctrl.step      = (state_q == ST_LOG) && (cnt_q != '0);
    mctrl.mul       = (state_q == ST_DB);
  end

  // shared sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (out_load) begin
      count_q <= '0;
    end else if (smp_en) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign right_smp = mono_q ? in_if.left_sample[SB-1:0] : in_if.right_sample[SB-1:0];

  sbm_lane #(.SB(SB), .EW(EW), .CW(CW)) u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lctrl),
    .sample_i (in_if.left_sample[SB-1:0]),
    .count_i  (count_q),
    .peak_o   (pk_l),
    .rms_o    (rms_l)
  );

  sbm_lane #(.SB(SB), .EW(EW), .CW(CW)) u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lctrl),
    .sample_i (right_smp),
    .count_i  (count_q),
    .peak_o   (pk_r),
    .rms_o    (rms_r)
  );

  sbm_merge #(.SB(SB)) u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (mctrl),
    .rms_l_i (rms_l),
    .rms_r_i (rms_r),
    .level_o (level)
  );

  // sticky clip flag
  assign clip_now = (FIELD_W'(pk_l) >= thr_q) || (FIELD_W'(pk_r) >= thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (out_load && clip_now) begin
      clip_q <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_if.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pk_l_q     <= FIELD_W'(pk_l);
      pk_r_q     <= FIELD_W'(pk_r);
      rms_l_q    <= FIELD_W'(rms_l);
      rms_r_q    <= FIELD_W'(rms_r);
      max_q      <= FIELD_W'((pk_l > pk_r) ? pk_l : pk_r);
      clip_out_q <= clip_q || clip_now;
      level_q    <= level;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.peak_left  = pk_l_q;
  assign out_if.peak_right = pk_r_q;
  assign out_if.rms_left   = rms_l_q;
  assign out_if.rms_right  = rms_r_q;
  assign out_if.max_peak   = max_q;
  assign out_if.clip_seen  = clip_out_q;
  assign out_if.level_db   = level_q;

  // checks
  `SBM_ASSERT_NXT(a_busy_after_last, clk_i, rst_ni,
                  in_acc && in_if.last_in_block, !in_if.ready)
  `SBM_ASSERT_IMP(a_level_range, clk_i, rst_ni, out_if.valid,
                  (out_if.level_db <= 0) && (out_if.level_db >= LEVEL_FLOOR))
  `SBM_ASSERT_NXT(a_clip_sticky, clk_i, rst_ni,
                  out_if.valid && out_if.clip_seen, clip_q)

endmodule
